/* design/vref_pkg.sv */
// shared constants for the vector reflection core
package vref_pkg;

    // default component width, signed q8.8 at 16 bits
    localparam int COMPONENT_WIDTH_DEF = 16;

endpackage

/* design/vector_reflection_core.sv */
// vector reflection core: r = 2(i.s)s/(s.s) - i, pipelined with a restoring divider per lane
//
//  channel | dir | tdata (low bit first)                          | tuser
//  s_      | in  | incident_x, incident_y, incident_z,            | -
//          |     | normal_x, normal_y, normal_z                   |
//  m_      | out | reflected_x, reflected_y, reflected_z          | degenerate, clipped
//
// one beat enters per cycle unless m_ stalls; the divider retires one quotient bit per stage
// over COMPONENT_WIDTH + 2 stages
// reset clears only the valid bits; the data registers carry no reset
// a stall on m_ freezes the whole pipeline, so s_tready follows !m_tvalid || m_tready
// zero normal gives a zero vector with degenerate set
module vector_reflection_core #(
    parameter int COMPONENT_WIDTH = vref_pkg::COMPONENT_WIDTH_DEF
) (
    input  logic                                        aclk,
    input  logic                                        aresetn,
    input  logic                                        s_tvalid,
    output logic                                        s_tready,
    // incident_x, incident_y, incident_z, normal_x, normal_y, normal_z
    input  logic [((6*COMPONENT_WIDTH+7)/8)*8-1:0]      s_tdata,
    output logic                                        m_tvalid,
    input  logic                                        m_tready,
    // reflected_x, reflected_y, reflected_z
    output logic [((3*COMPONENT_WIDTH+7)/8)*8-1:0]      m_tdata,
    // degenerate, clipped
    output logic [1:0]                                  m_tuser
);

    localparam int W   = COMPONENT_WIDTH;
    localparam int PW  = 2*W;          // product width
    localparam int DW  = 2*W + 1;      // signed dot product width
    localparam int NW  = 3*W + 1;      // numerator width
    localparam int QB  = W + 2;        // quotient bits
    localparam int KW  = W + 4;        // signed result before saturation
    localparam int OTW = ((3*W+7)/8)*8;

    localparam logic signed [KW-1:0] VMAX = KW'((64'sd1 <<< (W-1)) - 64'sd1);
    localparam logic signed [KW-1:0] VMIN = -VMAX - KW'(1);

    logic en;
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    // stage 1: products and squares
    logic                 v1_reg;
    logic signed [W-1:0]  ix1_reg [0:2];
    logic signed [W-1:0]  sx1_reg [0:2];
    logic signed [PW-1:0] pi1_reg [0:2];
    logic        [PW-1:0] ps1_reg [0:2];

    // stage 2: dot product and squared length
    logic                 v2_reg;
    logic signed [W-1:0]  ix2_reg [0:2];
    logic signed [W-1:0]  sx2_reg [0:2];
    logic signed [DW-1:0] d2_reg;
    logic        [PW-1:0] q2_reg;

    // stage 3: magnitudes and signs
    logic                 v3_reg;
    logic signed [W-1:0]  ix3_reg [0:2];
    logic        [W-1:0]  sm3_reg [0:2];
    logic                 xn3_reg [0:2];
    logic        [PW-1:0] dm3_reg;
    logic        [PW-1:0] q3_reg;
    logic                 deg3_reg;

    // stage 4: partial products of |d| * |s_c|
    logic                 v4_reg;
    logic signed [W-1:0]  ix4_reg [0:2];
    logic                 xn4_reg [0:2];
    logic        [PW-1:0] plo4_reg [0:2];
    logic        [PW-1:0] phi4_reg [0:2];
    logic        [PW-1:0] q4_reg;
    logic                 deg4_reg;

    // divider stages, index 0 holds the loaded numerator
    logic                 dv_v_reg   [0:QB];
    logic        [PW-1:0] dv_rem_reg [0:QB][0:2];
    logic        [QB-1:0] dv_low_reg [0:QB][0:2];
    logic        [QB-1:0] dv_quo_reg [0:QB][0:2];
    logic signed [W-1:0]  dv_ix_reg  [0:QB][0:2];
    logic                 dv_xn_reg  [0:QB][0:2];
    logic        [PW-1:0] dv_q_reg   [0:QB];
    logic                 dv_deg_reg [0:QB];

    // input unpack and stage 1
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= s_tvalid;
        end
    end

    for (genvar c = 0; c < 3; c++) begin : g_st1
        logic signed [W-1:0] ix_in;
        logic signed [W-1:0] sx_in;
        assign ix_in = s_tdata[c*W +: W];
        assign sx_in = s_tdata[(c+3)*W +: W];
        always_ff @(posedge aclk) begin
            if (en) begin
                ix1_reg[c] <= ix_in;
                sx1_reg[c] <= sx_in;
                pi1_reg[c] <= PW'(ix_in * sx_in);
                ps1_reg[c] <= PW'(sx_in * sx_in);
            end
        end
    end

    // stage 2: sums
    logic signed [DW-1:0] d2_next;
    logic        [PW-1:0] q2_next;
    assign d2_next = {pi1_reg[0][PW-1], pi1_reg[0]} + {pi1_reg[1][PW-1], pi1_reg[1]}
                   + {pi1_reg[2][PW-1], pi1_reg[2]};
    assign q2_next = ps1_reg[0] + ps1_reg[1] + ps1_reg[2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (en) begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            d2_reg  <= d2_next;
            q2_reg  <= q2_next;
            ix2_reg <= ix1_reg;
            sx2_reg <= sx1_reg;
        end
    end

    // stage 3: magnitudes
    logic signed [DW-1:0] dabs_next;
    assign dabs_next = d2_reg[DW-1] ? -d2_reg : d2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (en) begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dm3_reg  <= dabs_next[PW-1:0];
            q3_reg   <= q2_reg;
            deg3_reg <= (q2_reg == '0);
            ix3_reg  <= ix2_reg;
        end
    end

    for (genvar c = 0; c < 3; c++) begin : g_st3
        always_ff @(posedge aclk) begin
            if (en) begin
                sm3_reg[c] <= sx2_reg[c][W-1] ? W'(-sx2_reg[c]) : W'(sx2_reg[c]);
                xn3_reg[c] <= d2_reg[DW-1] ^ sx2_reg[c][W-1];
            end
        end
    end

    // stage 4: split multiply, two w by w products per lane
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v4_reg <= 1'b0;
        end else if (en) begin
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            q4_reg   <= q3_reg;
            deg4_reg <= deg3_reg;
            ix4_reg  <= ix3_reg;
            xn4_reg  <= xn3_reg;
        end
    end

    for (genvar c = 0; c < 3; c++) begin : g_st4
        always_ff @(posedge aclk) begin
            if (en) begin
                plo4_reg[c] <= PW'(dm3_reg[W-1:0] * sm3_reg[c]);
                phi4_reg[c] <= PW'(dm3_reg[PW-1:W] * sm3_reg[c]);
            end
        end
    end

    // divider load: numerator 2 |d| |s_c|, top bits seed the remainder
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dv_v_reg[0] <= 1'b0;
        end else if (en) begin
            dv_v_reg[0] <= v4_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dv_q_reg[0]   <= q4_reg;
            dv_deg_reg[0] <= deg4_reg;
        end
    end

    for (genvar c = 0; c < 3; c++) begin : g_load
        logic [3*W-1:0] prod;
        logic [NW-1:0]  num;
        assign prod = {phi4_reg[c], {W{1'b0}}} + {{W{1'b0}}, plo4_reg[c]};
        assign num  = {prod, 1'b0};
        always_ff @(posedge aclk) begin
            if (en) begin
                dv_rem_reg[0][c] <= {1'b0, num[NW-1:QB]};
                dv_low_reg[0][c] <= num[QB-1:0];
                dv_quo_reg[0][c] <= '0;
                dv_ix_reg[0][c]  <= ix4_reg[c];
                dv_xn_reg[0][c]  <= xn4_reg[c];
            end
        end
    end

    // divider steps: one compare and subtract per lane per stage
    for (genvar k = 1; k <= QB; k++) begin : g_div
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                dv_v_reg[k] <= 1'b0;
            end else if (en) begin
                dv_v_reg[k] <= dv_v_reg[k-1];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                dv_q_reg[k]   <= dv_q_reg[k-1];
                dv_deg_reg[k] <= dv_deg_reg[k-1];
            end
        end

        for (genvar c = 0; c < 3; c++) begin : g_lane
            logic [PW:0] trial;
            logic [PW:0] dvs;
            logic        ge;
            logic [PW:0] diff;
            assign trial = {dv_rem_reg[k-1][c], dv_low_reg[k-1][c][QB-1]};
            assign dvs   = {1'b0, dv_q_reg[k-1]};
            assign ge    = (trial >= dvs);
            assign diff  = trial - dvs;
            always_ff @(posedge aclk) begin
                if (en) begin
                    dv_rem_reg[k][c] <= ge ? diff[PW-1:0] : trial[PW-1:0];
                    dv_low_reg[k][c] <= {dv_low_reg[k-1][c][QB-2:0], 1'b0};
                    dv_quo_reg[k][c] <= {dv_quo_reg[k-1][c][QB-2:0], ge};
                    dv_ix_reg[k][c]  <= dv_ix_reg[k-1][c];
                    dv_xn_reg[k][c]  <= dv_xn_reg[k-1][c];
                end
            end
        end
    end

    // final stage: apply sign, subtract i, truncate toward zero, saturate
    logic [W-1:0] res_next [0:2];
    logic [2:0]   clip_next;

    for (genvar c = 0; c < 3; c++) begin : g_fin
        logic signed [KW-1:0] qs;
        logic signed [KW-1:0] ixe;
        logic signed [KW-1:0] kraw;
        logic signed [KW-1:0] kcor;
        logic                 frac;
        assign qs   = {2'b00, dv_quo_reg[QB][c]};
        assign ixe  = KW'(dv_ix_reg[QB][c]);
        assign kraw = dv_xn_reg[QB][c] ? (-qs - ixe) : (qs - ixe);
        assign frac = (dv_rem_reg[QB][c] != '0);
        always_comb begin
            kcor = kraw;
            if (frac) begin
                if (!dv_xn_reg[QB][c] && kraw < 0) begin
                    kcor = kraw + KW'(1);
                end else if (dv_xn_reg[QB][c] && kraw > 0) begin
                    kcor = kraw - KW'(1);
                end
            end
            if (kcor > VMAX) begin
                res_next[c]  = VMAX[W-1:0];
                clip_next[c] = 1'b1;
            end else if (kcor < VMIN) begin
                res_next[c]  = VMIN[W-1:0];
                clip_next[c] = 1'b1;
            end else begin
                res_next[c]  = kcor[W-1:0];
                clip_next[c] = 1'b0;
            end
        end
    end

    // output register
    logic [3*W-1:0] res_reg;
    logic           deg_reg;
    logic           clip_reg;
    logic           out_v_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_v_reg <= 1'b0;
        end else if (en) begin
            out_v_reg <= dv_v_reg[QB];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            if (dv_deg_reg[QB]) begin
                res_reg  <= '0;
                deg_reg  <= 1'b1;
                clip_reg <= 1'b0;
            end else begin
                res_reg  <= {res_next[2], res_next[1], res_next[0]};
                deg_reg  <= 1'b0;
                clip_reg <= |clip_next;
            end
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = OTW'(res_reg);
    assign m_tuser  = {clip_reg, deg_reg};

`ifndef SYNTHESIS
    // a zero normal always yields a zero, unclipped vector
    a_degenerate_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> (m_tdata[3*W-1:0] == '0) && !m_tuser[1])
        else $error("degenerate result not zero");

    // a clipped beat carries at least one component at a range limit
    a_clip_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1] |->
            (res_reg[W-1:0] == VMAX[W-1:0]) || (res_reg[W-1:0] == VMIN[W-1:0]) ||
            (res_reg[2*W-1:W] == VMAX[W-1:0]) || (res_reg[2*W-1:W] == VMIN[W-1:0]) ||
            (res_reg[3*W-1:2*W] == VMAX[W-1:0]) || (res_reg[3*W-1:2*W] == VMIN[W-1:0]))
        else $error("clipped flag without saturated component");

    // a frozen pipeline keeps its last divider stage unchanged
    a_stall_freeze: assert property (@(posedge aclk) disable iff (!aresetn)
        !en |=> $stable(dv_v_reg[QB]) && $stable(dv_quo_reg[QB][0]))
        else $error("pipeline moved during stall");
`endif

endmodule

/* bench/vref_checker.sv */
// checker for the vector reflection core: predicts each result beat and compares it
`timescale 1ns / 1ps

module vref_checker #(
    parameter int CW = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    input  logic                                s_tready,
    input  logic [((6*CW+7)/8)*8-1:0]           s_tdata,
    input  logic                                m_tvalid,
    input  logic                                m_tready,
    input  logic [((3*CW+7)/8)*8-1:0]           m_tdata,
    input  logic [1:0]                          m_tuser,
    output int                                  fail_count,
    output int                                  pending
);

    typedef struct packed {
        logic [CW-1:0] rx;
        logic [CW-1:0] ry;
        logic [CW-1:0] rz;
        logic          degenerate;
        logic          clipped;
    } reflection_t;

    reflection_t reflections_due[$];

    // exact reflection, truncated toward zero, then saturated
    function automatic reflection_t reflect(input logic [((6*CW+7)/8)*8-1:0] beat);
        reflection_t r;
        logic signed [127:0] iv[3], sv[3];
        logic signed [127:0] dot, norm2, num, q, k, vmax, vmin;
        logic signed [CW-1:0] f;
        begin
            for (int c = 0; c < 3; c++) begin
                f = beat[c*CW +: CW];
                iv[c] = f;
                f = beat[(3+c)*CW +: CW];
                sv[c] = f;
            end
            dot = 0;
            norm2 = 0;
            for (int c = 0; c < 3; c++) begin
                dot += iv[c] * sv[c];
                norm2 += sv[c] * sv[c];
            end
            r = '0;
            if (norm2 == 0) begin
                r.degenerate = 1'b1;
                return r;
            end
            vmax = (128'sd1 <<< (CW-1)) - 1;
            vmin = -vmax - 1;
            for (int c = 0; c < 3; c++) begin
                // numerator 2(i.s)s_c - i_c(s.s); signed divide truncates toward zero
                num = 2 * dot * sv[c] - iv[c] * norm2;
                q = num / norm2;
                k = q;
                if (k > vmax) begin
                    k = vmax;
                    r.clipped = 1'b1;
                end
                if (k < vmin) begin
                    k = vmin;
                    r.clipped = 1'b1;
                end
                if (c == 0) r.rx = k[CW-1:0];
                else if (c == 1) r.ry = k[CW-1:0];
                else r.rz = k[CW-1:0];
            end
            return r;
        end
    endfunction

    assign pending = reflections_due.size();

    // watch both channels at the rising edge
    always @(posedge aclk) begin
        reflection_t want, got;
        if (!aresetn) begin
            fail_count <= 0;
        end else begin
            if (s_tvalid && s_tready) reflections_due.push_back(reflect(s_tdata));
            if (m_tvalid && m_tready) begin
                got.rx = m_tdata[0 +: CW];
                got.ry = m_tdata[CW +: CW];
                got.rz = m_tdata[2*CW +: CW];
                got.degenerate = m_tuser[0];
                got.clipped = m_tuser[1];
                if (reflections_due.size() == 0) begin
                    if (fail_count < 10) $display("unexpected result beat %h", got);
                    fail_count <= fail_count + 1;
                end else begin
                    want = reflections_due.pop_front();
                    if (want !== got) begin
                        if (fail_count < 10)
                            $display("mismatch: exp %h %h %h %b %b, got %h %h %h %b %b",
                                want.rx, want.ry, want.rz, want.degenerate, want.clipped,
                                got.rx, got.ry, got.rz, got.degenerate, got.clipped);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

/* bench/tb.sv */
// testbench top: drives vector beats into the reflection core and gives the verdict
`timescale 1ns / 1ps

module tb;

    localparam int CW = vref_pkg::COMPONENT_WIDTH_DEF;
    localparam int SW = ((6*CW+7)/8)*8;
    localparam int MW = ((3*CW+7)/8)*8;
    localparam int LATENCY = CW + 8;
    localparam int RANDOM_BEATS = 1130;
    localparam int CYCLE_LIMIT = 200000;

    logic          aclk = 1'b0;
    logic          aresetn = 1'b0;
    logic          s_tvalid = 1'b0;
    logic          s_tready;
    logic [SW-1:0] s_tdata = '0;
    logic          m_tvalid;
    logic          m_tready = 1'b0;
    logic [MW-1:0] m_tdata;
    logic [1:0]    m_tuser;
    int            fail_count;
    int            pending;
    int            cycles = 0;
    bit            calm = 1'b0;
    bit            hold_off = 1'b0;

    vector_reflection_core #(.COMPONENT_WIDTH(CW)) dut (
        .aclk, .aresetn, .s_tvalid, .s_tready, .s_tdata,
        .m_tvalid, .m_tready, .m_tdata, .m_tuser
    );

    vref_checker #(.CW(CW)) checker_i (
        .aclk, .aresetn, .s_tvalid, .s_tready, .s_tdata,
        .m_tvalid, .m_tready, .m_tdata, .m_tuser, .fail_count, .pending
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // cycle limit
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // receiver: random stalls, a calm stretch, and one long hold-off
    always @(negedge aclk) begin
        if (hold_off) m_tready <= 1'b0;
        else if (calm) m_tready <= 1'b1;
        else m_tready <= ($urandom_range(99) >= 32);
    end

    function automatic logic [CW-1:0] pick_component();
        case ($urandom_range(9))
            0: return {1'b1, {(CW-1){1'b0}}};
            1: return {1'b0, {(CW-1){1'b1}}};
            2: return '0;
            3: return CW'($urandom_range(512)) - CW'(256);
            4: return CW'($urandom_range(8));
            default: return CW'($urandom);
        endcase
    endfunction

    // offer one beat at the falling edge and hold until accepted
    task automatic send_vector(input logic [CW-1:0] c[6]);
        begin
            for (int i = 0; i < 6; i++) s_tdata[i*CW +: CW] <= c[i];
            s_tvalid <= 1'b1;
            @(posedge aclk);
            while (!s_tready) @(posedge aclk);
            @(negedge aclk);
            if (calm || hold_off || $urandom_range(99) >= 32) return;
            s_tvalid <= 1'b0;
            @(negedge aclk);
            while ($urandom_range(99) < 32) @(negedge aclk);
        end
    endtask

    logic [CW-1:0] vec[6];
    logic [CW-1:0] smin, smax;

    initial begin
        smin = {1'b1, {(CW-1){1'b0}}};
        smax = {1'b0, {(CW-1){1'b1}}};
        repeat (2) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed: zero normal, extremes, saturating cases, unit normals
        vec = '{16'h0100, 16'h0200, 16'h0300, 16'h0000, 16'h0000, 16'h0000}; send_vector(vec);
        vec = '{smin, smin, smin, 16'h0000, 16'h0000, 16'h0000}; send_vector(vec);
        vec = '{smax, smax, smax, smax, smax, smax}; send_vector(vec);
        vec = '{smin, smin, smin, smin, smin, smin}; send_vector(vec);
        vec = '{smax, smin, smax, smin, smax, smin}; send_vector(vec);
        vec = '{smax, smax, 16'h0000, 16'h0001, 16'h0001, 16'h0000}; send_vector(vec);
        vec = '{smin, smax, smin, 16'h0001, 16'h0001, 16'h0001}; send_vector(vec);
        vec = '{16'h0100, 16'h0000, 16'h0000, 16'h0100, 16'h0000, 16'h0000}; send_vector(vec);
        vec = '{16'h0100, 16'h0100, 16'h0000, 16'h0000, 16'h0100, 16'h0000}; send_vector(vec);
        vec = '{16'h0003, 16'hfffd, 16'h0007, 16'h0003, 16'h0005, 16'hffff}; send_vector(vec);
        vec = '{16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'h0000, 16'h0001}; send_vector(vec);
        vec = '{16'h0000, 16'h0000, 16'h0000, 16'h1234, 16'h8000, 16'h7fff}; send_vector(vec);
        vec = '{16'h5555, 16'haaaa, 16'h5555, 16'haaaa, 16'h5555, 16'haaaa}; send_vector(vec);

        // random beats; calm stretch, long receiver hold-off, drain pause
        for (int n = 0; n < RANDOM_BEATS; n++) begin
            if (n == 300) calm = 1'b1;
            if (n == 450) calm = 1'b0;
            if (n == 600) begin
                hold_off = 1'b1;
                fork
                    begin
                        repeat (3 * LATENCY + 50) @(negedge aclk);
                        hold_off = 1'b0;
                    end
                join_none
            end
            if (n == 800) begin
                s_tvalid <= 1'b0;
                @(negedge aclk);
                while (pending != 0) @(negedge aclk);
            end
            for (int i = 0; i < 6; i++) vec[i] = pick_component();
            if ($urandom_range(49) == 0) begin
                vec[3] = '0;
                vec[4] = '0;
                vec[5] = '0;
            end
            send_vector(vec);
        end
        s_tvalid <= 1'b0;

        // drain
        while (pending != 0) @(negedge aclk);
        repeat (LATENCY + 10) @(negedge aclk);
        if (fail_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

/* filelist.f */
design/vref_pkg.sv
design/vector_reflection_core.sv
bench/vref_checker.sv
bench/tb.sv
